// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion shorthands, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pmhc_pkg.sv -----
// ----------------------------------------------------------------------------
// pmhc_pkg
// shared types and constants of the particle mesh height clamp
// ----------------------------------------------------------------------------
package pmhc_pkg;

    localparam int DATA_W     = 32;
    localparam int SLOT_W     = 8;
    localparam int CNT_W      = 9;
    localparam int CLEAR_W    = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEARANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRI_COUNT = 3'd4;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] corner_a_x;
        logic signed [DATA_W-1:0] corner_a_z;
        logic signed [DATA_W-1:0] corner_b_x;
        logic signed [DATA_W-1:0] corner_b_z;
        logic signed [DATA_W-1:0] corner_c_x;
        logic signed [DATA_W-1:0] corner_c_z;
        logic signed [DATA_W-1:0] corner_a_height;
        logic signed [DATA_W-1:0] particle_x;
        logic signed [DATA_W-1:0] particle_y;
        logic signed [DATA_W-1:0] particle_z;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] adjusted_y;
        logic [CNT_W-1:0]         clamp_count;
    } t_out;

    // sign of a cross product
    typedef struct packed {
        logic pos;
        logic neg;
    } t_sign;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN
    } t_state;

endpackage

// ----- design/pmhc_ram.sv -----
// ----------------------------------------------------------------------------
// pmhc_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pmhc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/pmhc_cross.sv -----
// ----------------------------------------------------------------------------
// pmhc_cross
// exact sign of uz*vx - ux*vz, three register stages
// ----------------------------------------------------------------------------
module pmhc_cross #(
    parameter int DW = 34
) (
    input  logic                 i_clk,
    input  logic signed [DW-1:0] i_ux,
    input  logic signed [DW-1:0] i_uz,
    input  logic signed [DW-1:0] i_vx,
    input  logic signed [DW-1:0] i_vz,
    output pmhc_pkg::t_sign      o_sign
);

    import pmhc_pkg::*;

    localparam int LW  = DW / 2;
    localparam int HIW = DW - LW;
    localparam int PW  = 2 * DW;

    // multiplier operand split into a signed upper and an unsigned lower half
    logic signed [HIW-1:0] w_vx_hi;
    logic signed [HIW-1:0] w_vz_hi;
    logic signed [LW:0]    w_vx_lo;
    logic signed [LW:0]    w_vz_lo;

    logic signed [DW+HIW-1:0] r_p_hi;
    logic signed [DW+LW:0]    r_p_lo;
    logic signed [DW+HIW-1:0] r_q_hi;
    logic signed [DW+LW:0]    r_q_lo;
    logic signed [PW-1:0]     r_p;
    logic signed [PW-1:0]     r_q;
    t_sign                    r_sign;

    assign w_vx_hi = i_vx[DW-1:LW];
    assign w_vz_hi = i_vz[DW-1:LW];
    assign w_vx_lo = signed'({1'b0, i_vx[LW-1:0]});
    assign w_vz_lo = signed'({1'b0, i_vz[LW-1:0]});

    always_ff @(posedge i_clk) begin
        // partial products
        r_p_hi <= i_uz * w_vx_hi;
        r_p_lo <= i_uz * w_vx_lo;
        r_q_hi <= i_ux * w_vz_hi;
        r_q_lo <= i_ux * w_vz_lo;
        // full products
        r_p    <= (PW'(r_p_hi) <<< LW) + PW'(r_p_lo);
        r_q    <= (PW'(r_q_hi) <<< LW) + PW'(r_q_lo);
        // compare
        r_sign.pos <= r_p > r_q;
        r_sign.neg <= r_p < r_q;
    end

    assign o_sign = r_sign;

endmodule

// ----- design/particle_mesh_height_clamp_unit.sv -----
// ----------------------------------------------------------------------------
// particle_mesh_height_clamp_unit
// triangle table with a same-side point-in-triangle walk that clamps height
// ----------------------------------------------------------------------------
// usage
//   input channel (i_valid / o_ready / i_data) carries two kinds of beat:
//   a load beat writes one triangle into the table at its slot and gives
//   no result; a query beat walks triangles 0 .. n-1, with n =
//   min(triangle_count, MAX_TRIANGLES), and gives one result beat.
//   output channel (o_valid / i_ready / o_data) holds the final height and
//   the number of clamps in an output register.
//   a query's result waits for the walk, which reads one table entry per
//   cycle from the triangle ram, and for the walk pipeline to drain. o_ready
//   returns the cycle after the result is written to the output register,
//   so the next beat is taken while the previous result still waits there:
//   with a ready receiver a new query is taken once the previous one has
//   drained, and loads are taken every cycle while the block is idle.
//   if the receiver stalls, a finished query waits in the drain state until
//   the output register is free and the input waits with it; a lone result
//   waiting in the output register holds nothing up.
//   reset clears the control state, the walk pipeline valids and the
//   configuration registers; table entries are undefined until loaded.
//   configuration writes are taken at any edge with i_cfg_we high and must
//   only be made while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module particle_mesh_height_clamp_unit #(
    parameter int MAX_TRIANGLES = 256,
    parameter int COORD_WIDTH   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  pmhc_pkg::t_in                       i_data,
    // output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output pmhc_pkg::t_out                      o_data,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [pmhc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pmhc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import pmhc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 2;                  // differences and running height
    localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int KW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam int MW = 7 * CW;                  // one table row
    localparam logic [KW-1:0] MAX_K = KW'(MAX_TRIANGLES);
    // most negative height, -2^(CW-1)
    localparam logic signed [DW-1:0] LO_LIM = {3'b111, (CW-1)'(0)};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DATA_W-1:0]  r_off_x;
    logic [DATA_W-1:0]  r_off_y;
    logic [DATA_W-1:0]  r_off_z;
    logic [CLEAR_W-1:0] r_clear;
    logic [CNT_W-1:0]   r_tri_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x     <= '0;
            r_off_y     <= '0;
            r_off_z     <= '0;
            r_clear     <= '0;
            r_tri_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OFFSET_X:  r_off_x     <= i_cfg_data[DATA_W-1:0];
                CFG_OFFSET_Y:  r_off_y     <= i_cfg_data[DATA_W-1:0];
                CFG_OFFSET_Z:  r_off_z     <= i_cfg_data[DATA_W-1:0];
                CFG_CLEARANCE: r_clear     <= i_cfg_data[CLEAR_W-1:0];
                CFG_TRI_COUNT: r_tri_count <= i_cfg_data[CNT_W-1:0];
                default: ;     // unknown index, ignored
            endcase
        end
    end

    // offsets taken as signed CW-bit values
    logic signed [CW-1:0] w_ox;
    logic signed [CW-1:0] w_oy;
    logic signed [CW-1:0] w_oz;

    assign w_ox = r_off_x[CW-1:0];
    assign w_oy = r_off_y[CW-1:0];
    assign w_oz = r_off_z[CW-1:0];

    // ------------------------------------------------------------------
    // handshake and control
    // ------------------------------------------------------------------
    t_state          r_state;
    t_state          n_state;
    logic [KW-1:0]   r_idx;          // next table entry to read
    logic [KW-1:0]   r_n;            // entries walked by this query
    logic [KW-1:0]   w_n_new;
    logic [KW-1:0]   w_tc_ext;
    logic            w_in_acc;
    logic            w_load;
    logic            w_query;
    logic            w_issue;
    logic            w_finish;
    logic            w_pipe_busy;
    logic            w_ram_we;

    // walk pipeline valids: ram read, offset add, differences, three cross stages
    logic r_vld_rd;
    logic r_vld_a;
    logic r_vld_b;
    logic r_vld_c;
    logic r_vld_d;
    logic r_vld_e;

    logic             r_out_valid;
    t_out             r_out;
    logic [CNT_W-1:0] r_clamps;
    logic             w_clamp;

    assign w_in_acc = i_valid && o_ready;
    assign w_load   = w_in_acc && (i_data.operation == OP_LOAD);
    assign w_query  = w_in_acc && (i_data.operation == OP_QUERY);

    // walk length, clipped to the table depth
    assign w_tc_ext = KW'(r_tri_count);
    assign w_n_new  = (w_tc_ext > MAX_K) ? MAX_K : w_tc_ext;

    assign w_pipe_busy = r_vld_rd || r_vld_a || r_vld_b || r_vld_c || r_vld_d || r_vld_e;

    // loads beyond the table are dropped
    assign w_ram_we = w_load && (KW'(i_data.slot) < MAX_K);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_state = (w_n_new == '0) ? S_DRAIN : S_WALK;
                end
            end
            S_WALK: begin
                if ((r_idx + KW'(1)) == r_n) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready  = 1'b0;
        w_issue  = 1'b0;
        w_finish = 1'b0;
        case (r_state)
            S_IDLE:  o_ready = 1'b1;
            S_WALK:  w_issue = 1'b1;
            // last clamp applied and output register free or being emptied
            S_DRAIN: w_finish = !w_pipe_busy && (!r_out_valid || i_ready);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_n         <= '0;
            r_vld_rd    <= 1'b0;
            r_vld_a     <= 1'b0;
            r_vld_b     <= 1'b0;
            r_vld_c     <= 1'b0;
            r_vld_d     <= 1'b0;
            r_vld_e     <= 1'b0;
            r_out_valid <= 1'b0;
            r_clamps    <= '0;
        end else begin
            r_state  <= n_state;
            r_vld_rd <= w_issue;
            r_vld_a  <= r_vld_rd;
            r_vld_b  <= r_vld_a;
            r_vld_c  <= r_vld_b;
            r_vld_d  <= r_vld_c;
            r_vld_e  <= r_vld_d;
            if (w_query) begin
                r_idx <= '0;
                r_n   <= w_n_new;
            end else if (w_issue) begin
                r_idx <= r_idx + KW'(1);
            end
            if (w_query) begin
                r_clamps <= '0;
            end else if (w_clamp) begin
                r_clamps <= r_clamps + CNT_W'(1);
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // triangle table, one row per slot: {top, cz, cx, bz, bx, az, ax}
    // ------------------------------------------------------------------
    logic [MW-1:0] w_wr_row;
    logic [MW-1:0] w_rd_row;

    assign w_wr_row = {i_data.corner_a_height[CW-1:0],
                       i_data.corner_c_z[CW-1:0], i_data.corner_c_x[CW-1:0],
                       i_data.corner_b_z[CW-1:0], i_data.corner_b_x[CW-1:0],
                       i_data.corner_a_z[CW-1:0], i_data.corner_a_x[CW-1:0]};

    pmhc_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_TRIANGLES)
    ) u_tri_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (AW'(i_data.slot)),
        .i_wr_data (w_wr_row),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (w_rd_row)
    );

    logic signed [CW-1:0] w_ax;
    logic signed [CW-1:0] w_az;
    logic signed [CW-1:0] w_bx;
    logic signed [CW-1:0] w_bz;
    logic signed [CW-1:0] w_cx;
    logic signed [CW-1:0] w_cz;
    logic signed [CW-1:0] w_top;

    assign w_ax  = w_rd_row[0*CW +: CW];
    assign w_az  = w_rd_row[1*CW +: CW];
    assign w_bx  = w_rd_row[2*CW +: CW];
    assign w_bz  = w_rd_row[3*CW +: CW];
    assign w_cx  = w_rd_row[4*CW +: CW];
    assign w_cz  = w_rd_row[5*CW +: CW];
    assign w_top = w_rd_row[6*CW +: CW];

    // ------------------------------------------------------------------
    // walk datapath
    // ------------------------------------------------------------------
    logic signed [CW-1:0] r_px;
    logic signed [CW-1:0] r_pz;
    logic signed [DW-1:0] r_height;        // running height

    // stage a: corners moved by the mesh offset, triangle level
    logic signed [CW:0]   r_ax_a;
    logic signed [CW:0]   r_az_a;
    logic signed [CW:0]   r_bx_a;
    logic signed [CW:0]   r_bz_a;
    logic signed [CW:0]   r_cx_a;
    logic signed [CW:0]   r_cz_a;
    logic signed [CW:0]   r_lvl_a;

    // stage b: edge vectors and test vectors
    //   edge bc: u0 = c-b, v0 = p-b, v1 = a-b
    //   edge ac: u1 = c-a, v2 = p-a, v3 = b-a
    //   edge ab: u2 = b-a, v4 = p-a, v5 = c-a
    logic signed [DW-1:0] r_ux [3];
    logic signed [DW-1:0] r_uz [3];
    logic signed [DW-1:0] r_vx [6];
    logic signed [DW-1:0] r_vz [6];
    logic signed [CW:0]   r_lvl_b;
    logic signed [DW-1:0] r_hsat_b;
    logic signed [DW-1:0] w_h;

    // level and clamp target follow the cross units
    logic signed [CW:0]   r_lvl_c;
    logic signed [CW:0]   r_lvl_d;
    logic signed [CW:0]   r_lvl_e;
    logic signed [DW-1:0] r_hsat_c;
    logic signed [DW-1:0] r_hsat_d;
    logic signed [DW-1:0] r_hsat_e;

    t_sign w_sign [6];
    logic  w_side_bc;
    logic  w_side_ac;
    logic  w_side_ab;
    logic  w_inside;

    // level minus clearance, floored at the bottom of the coordinate range
    assign w_h = DW'(r_lvl_a) - DW'(signed'({1'b0, r_clear}));

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_px <= i_data.particle_x[CW-1:0];
            r_pz <= i_data.particle_z[CW-1:0];
        end

        r_ax_a  <= (CW+1)'(w_ax) + (CW+1)'(w_ox);
        r_az_a  <= (CW+1)'(w_az) + (CW+1)'(w_oz);
        r_bx_a  <= (CW+1)'(w_bx) + (CW+1)'(w_ox);
        r_bz_a  <= (CW+1)'(w_bz) + (CW+1)'(w_oz);
        r_cx_a  <= (CW+1)'(w_cx) + (CW+1)'(w_ox);
        r_cz_a  <= (CW+1)'(w_cz) + (CW+1)'(w_oz);
        r_lvl_a <= (CW+1)'(w_top) + (CW+1)'(w_oy);

        r_ux[0] <= DW'(r_cx_a) - DW'(r_bx_a);
        r_uz[0] <= DW'(r_cz_a) - DW'(r_bz_a);
        r_ux[1] <= DW'(r_cx_a) - DW'(r_ax_a);
        r_uz[1] <= DW'(r_cz_a) - DW'(r_az_a);
        r_ux[2] <= DW'(r_bx_a) - DW'(r_ax_a);
        r_uz[2] <= DW'(r_bz_a) - DW'(r_az_a);
        r_vx[0] <= DW'(r_px)   - DW'(r_bx_a);
        r_vz[0] <= DW'(r_pz)   - DW'(r_bz_a);
        r_vx[1] <= DW'(r_ax_a) - DW'(r_bx_a);
        r_vz[1] <= DW'(r_az_a) - DW'(r_bz_a);
        r_vx[2] <= DW'(r_px)   - DW'(r_ax_a);
        r_vz[2] <= DW'(r_pz)   - DW'(r_az_a);
        r_vx[3] <= DW'(r_bx_a) - DW'(r_ax_a);
        r_vz[3] <= DW'(r_bz_a) - DW'(r_az_a);
        r_vx[4] <= DW'(r_px)   - DW'(r_ax_a);
        r_vz[4] <= DW'(r_pz)   - DW'(r_az_a);
        r_vx[5] <= DW'(r_cx_a) - DW'(r_ax_a);
        r_vz[5] <= DW'(r_cz_a) - DW'(r_az_a);
        r_lvl_b  <= r_lvl_a;
        r_hsat_b <= (w_h < LO_LIM) ? LO_LIM : w_h;

        r_lvl_c  <= r_lvl_b;
        r_lvl_d  <= r_lvl_c;
        r_lvl_e  <= r_lvl_d;
        r_hsat_c <= r_hsat_b;
        r_hsat_d <= r_hsat_c;
        r_hsat_e <= r_hsat_d;

        // running height: start value on query, clamp target on a hit
        if (w_query) begin
            r_height <= DW'(signed'(i_data.particle_y[CW-1:0]));
        end else if (w_clamp) begin
            r_height <= r_hsat_e;
        end

        if (w_finish) begin
            r_out.adjusted_y  <= DATA_W'(r_height);
            r_out.clamp_count <= r_clamps;
        end
    end

    // six cross-product sign units, two per edge
    for (genvar k = 0; k < 6; k++) begin : g_cross
        pmhc_cross #(
            .DW (DW)
        ) u_cross (
            .i_clk  (i_clk),
            .i_ux   (r_ux[k/2]),
            .i_uz   (r_uz[k/2]),
            .i_vx   (r_vx[k]),
            .i_vz   (r_vz[k]),
            .o_sign (w_sign[k])
        );
    end

    // same side unless strictly opposite signs; zero counts as inside
    assign w_side_bc = !((w_sign[0].pos && w_sign[1].neg) || (w_sign[0].neg && w_sign[1].pos));
    assign w_side_ac = !((w_sign[2].pos && w_sign[3].neg) || (w_sign[2].neg && w_sign[3].pos));
    assign w_side_ab = !((w_sign[4].pos && w_sign[5].neg) || (w_sign[4].neg && w_sign[5].pos));
    assign w_inside  = w_side_bc && w_side_ac && w_side_ab;

    // only the final compare sits on the height loop
    assign w_clamp = r_vld_e && w_inside && (r_height > DW'(r_lvl_e));

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLIES(a_idle_pipe_empty, r_state == S_IDLE, !w_pipe_busy, "walk pipeline busy while idle")
    `ASSERT_IMPLIES(a_walk_in_range, r_state == S_WALK, r_idx < r_n, "table read past walk length")
    `ASSERT_IMPLIES(a_ram_wr_idle, w_ram_we, r_state == S_IDLE, "table written during a walk")
    `ASSERT_NEXT(a_result_loaded, w_finish, r_out_valid && (r_state == S_IDLE), "result not presented after drain")

endmodule
